[sv/fpr_pkg.sv]
// shared types and constants of the framed packet receiver
package fpr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd85;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd170;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 7'd56;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_CHECK = 4'd2,
    PH_TYPE  = 4'd3,
    PH_SRC   = 4'd4,
    PH_DST   = 4'd5,
    PH_FUNC  = 4'd6,
    PH_LEN   = 4'd7,
    PH_DATA  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    CTL_PARSE = 2'd0,
    CTL_READ  = 2'd1,
    CTL_LOAD  = 2'd2,
    CTL_SEND  = 2'd3
  } ctl_e;

endpackage

[sv/framed_packet_receiver.sv]
// framed packet receiver: sync hunt, header parse, sum check and payload readout
//
// input channel: one received byte per beat on rx_byte_i (in_valid_i / in_stall_o).
// frames are two sync bytes, a check byte, type, source, destination, function,
// a length byte and that many payload bytes; the sum of type through the last
// payload byte, mod 256, must equal the check byte.
// output channel: one beat per payload byte of a good frame, header fields on
// every beat, last_of_frame_o on the final one; an empty frame gives one beat
// with payload_present_o low (out_valid_o / out_stall_i).
// while parsing, the input never stalls. after the final byte of a good
// frame the input stalls while the payload ram is read back, each result beat
// in turn (ram read, output load, beat) plus any receiver stall, as the
// payload ram has a single read port. an empty frame's beat is ready in the
// cycle after its length byte.
// when the receiver stalls, the current beat holds and the readout waits.
// bad frames and over-long lengths are dropped and hunting resumes.
// reset returns to sync hunting with the configured register defaults; the
// payload ram needs no clearing.
// configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are taken at once.
module framed_packet_receiver
  import fpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    msg_type_o,
  output logic [BYTE_W-1:0]    source_module_o,
  output logic [BYTE_W-1:0]    dest_module_o,
  output logic [BYTE_W-1:0]    function_code_o,
  output logic [LEN_W-1:0]     payload_length_o,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic                 payload_present_o,
  output logic                 last_of_frame_o
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned XW = AW + LEN_W;

  // configuration
  logic [BYTE_W-1:0] sync_first_q, sync_second_q;
  logic [LEN_W-1:0]  max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
      max_len_q     <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        CFG_MAX_LEN:     max_len_q     <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // parser state
  phase_e            phase_q, phase_d;
  ctl_e              ctl_q, ctl_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] check_q, check_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [BYTE_W-1:0] src_q, src_d;
  logic [BYTE_W-1:0] dst_q, dst_d;
  logic [BYTE_W-1:0] func_q, func_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  rcv_q, rcv_d;
  logic [LEN_W-1:0]  rd_idx_q, rd_idx_d;
  logic [BYTE_W-1:0] pay_q, pay_d;
  logic              present_q, present_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;

  logic              in_acc, out_acc;
  logic [BYTE_W-1:0] sum_add;
  logic [LEN_W-1:0]  rcv_inc;
  logic              len_bad;
  logic              start_run, start_empty;
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic [XW-1:0]     waddr_x, raddr_x;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign sum_add = sum_q + rx_byte_i;
  assign rcv_inc = rcv_q + LEN_W'(1);
  assign len_bad = (rx_byte_i > {1'b0, max_len_q}) ||
                   ({1'b0, rx_byte_i} > 9'(PAYLOAD_DEPTH));
  assign waddr_x = XW'(rcv_q);
  assign raddr_x = XW'(rd_idx_q);

  // byte parser
  always_comb begin
    phase_d     = phase_q;
    sum_d       = sum_q;
    check_d     = check_q;
    type_d      = type_q;
    src_d       = src_q;
    dst_d       = dst_q;
    func_d      = func_q;
    len_d       = len_q;
    rcv_d       = rcv_q;
    ram_we      = 1'b0;
    start_run   = 1'b0;
    start_empty = 1'b0;
    if (in_acc) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (rx_byte_i == sync_first_q) begin
            sum_d   = '0;
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte_i == sync_second_q) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_SYNC1;
            rcv_d   = '0;
            sum_d   = '0;
          end
        end
        PH_CHECK: begin
          check_d = rx_byte_i;
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          sum_d   = sum_add;
          type_d  = rx_byte_i;
          phase_d = PH_SRC;
        end
        PH_SRC: begin
          sum_d   = sum_add;
          src_d   = rx_byte_i;
          phase_d = PH_DST;
        end
        PH_DST: begin
          sum_d   = sum_add;
          dst_d   = rx_byte_i;
          phase_d = PH_FUNC;
        end
        PH_FUNC: begin
          sum_d   = sum_add;
          func_d  = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (len_bad) begin
            phase_d = PH_SYNC1;
            rcv_d   = '0;
            sum_d   = '0;
          end else if (rx_byte_i == '0) begin
            len_d       = '0;
            start_empty = (sum_add == check_q);
            phase_d     = PH_SYNC1;
            rcv_d       = '0;
            sum_d       = '0;
          end else begin
            len_d   = rx_byte_i[LEN_W-1:0];
            sum_d   = sum_add;
            rcv_d   = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          ram_we = 1'b1;
          if (rcv_inc >= len_q) begin
            start_run = (sum_add == check_q);
            phase_d   = PH_SYNC1;
            rcv_d     = '0;
            sum_d     = '0;
          end else begin
            rcv_d = rcv_inc;
            sum_d = sum_add;
          end
        end
        default: begin
          phase_d = PH_SYNC1;
          rcv_d   = '0;
          sum_d   = '0;
        end
      endcase
    end
  end

  // readout sequencer: next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_PARSE: begin
        if (start_run) begin
          ctl_d = CTL_READ;
        end else if (start_empty) begin
          ctl_d = CTL_SEND;
        end
      end
      CTL_READ: ctl_d = CTL_LOAD;
      CTL_LOAD: ctl_d = CTL_SEND;
      CTL_SEND: begin
        if (out_acc) begin
          ctl_d = last_q ? CTL_PARSE : CTL_READ;
        end
      end
      default: ctl_d = CTL_PARSE;
    endcase
  end

  // readout sequencer: outputs
  always_comb begin
    ram_re      = 1'b0;
    rd_idx_d    = rd_idx_q;
    pay_d       = pay_q;
    present_d   = present_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    unique case (ctl_q)
      CTL_PARSE: begin
        if (start_run) begin
          rd_idx_d = '0;
        end else if (start_empty) begin
          pay_d       = '0;
          present_d   = 1'b0;
          last_d      = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      CTL_READ: ram_re = 1'b1;
      CTL_LOAD: begin
        pay_d       = ram_rdata;
        present_d   = 1'b1;
        last_d      = ((rd_idx_q + LEN_W'(1)) == len_q);
        out_valid_d = 1'b1;
      end
      CTL_SEND: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          rd_idx_d    = rd_idx_q + LEN_W'(1);
        end
      end
      default: out_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      ctl_q       <= CTL_PARSE;
      sum_q       <= '0;
      check_q     <= '0;
      type_q      <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      func_q      <= '0;
      len_q       <= '0;
      rcv_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      ctl_q       <= ctl_d;
      sum_q       <= sum_d;
      check_q     <= check_d;
      type_q      <= type_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      func_q      <= func_d;
      len_q       <= len_d;
      rcv_q       <= rcv_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q     <= pay_d;
    present_q <= present_d;
    last_q    <= last_d;
  end

  fpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_x[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (raddr_x[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o        = (ctl_q != CTL_PARSE);
  assign out_valid_o       = out_valid_q;
  assign msg_type_o        = type_q;
  assign source_module_o   = src_q;
  assign dest_module_o     = dst_q;
  assign function_code_o   = func_q;
  assign payload_length_o  = len_q;
  assign payload_byte_o    = pay_q;
  assign payload_present_o = present_q;
  assign last_of_frame_o   = last_q;

`ifndef SYNTH
  a_no_input_during_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result beat is pending");

  a_resume_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_of_frame_o) |=> !in_stall_o && !out_valid_o)
    else $error("parser did not resume after final beat");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_present_o) |-> (last_of_frame_o && payload_length_o == '0))
    else $error("empty frame beat malformed");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == CTL_READ) |-> (rd_idx_q < len_q))
    else $error("payload read past frame length");

  a_no_write_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q != CTL_PARSE) |-> !ram_we)
    else $error("payload write during readout");
`endif

endmodule

[sv/fpr_ram.sv]
// generic single-write single-read ram with registered read data
module fpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sim/fpr_checker.sv]
// checker for the framed packet receiver: parses the accepted input bytes and compares output beats
`timescale 1ns / 1ps

module fpr_checker
  import fpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [BYTE_W-1:0]    msg_type_i,
  input  logic [BYTE_W-1:0]    source_module_i,
  input  logic [BYTE_W-1:0]    dest_module_i,
  input  logic [BYTE_W-1:0]    function_code_i,
  input  logic [LEN_W-1:0]     payload_length_i,
  input  logic [BYTE_W-1:0]    payload_byte_i,
  input  logic                 payload_present_i,
  input  logic                 last_of_frame_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          beats_queued_o
);

  localparam int unsigned MEM_AW = (PAYLOAD_DEPTH_DEF > 1) ? $clog2(PAYLOAD_DEPTH_DEF) : 1;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] source_module;
    logic [BYTE_W-1:0] dest_module;
    logic [BYTE_W-1:0] function_code;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_present;
    logic              last_of_frame;
  } frame_beat_t;

  frame_beat_t frame_run_q[$];

  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;
  logic [LEN_W-1:0]  max_len;

  phase_e            hunt_phase;
  logic [BYTE_W-1:0] sum_acc;
  logic [BYTE_W-1:0] check_byte;
  logic [BYTE_W-1:0] hdr_type;
  logic [BYTE_W-1:0] hdr_src;
  logic [BYTE_W-1:0] hdr_dst;
  logic [BYTE_W-1:0] hdr_func;
  logic [LEN_W-1:0]  len_byte;
  logic [LEN_W-1:0]  data_cnt;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH_DEF];

  int unsigned mismatches;

  function automatic int unsigned field_mismatch(input string name,
                                                 input logic [BYTE_W-1:0] want,
                                                 input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic queue_frame_run();
    frame_beat_t b;
    int k;
    b.msg_type      = hdr_type;
    b.source_module = hdr_src;
    b.dest_module   = hdr_dst;
    b.function_code = hdr_func;
    if (len_byte == 0) begin
      b.payload_length  = '0;
      b.payload_byte    = '0;
      b.payload_present = 1'b0;
      b.last_of_frame   = 1'b1;
      frame_run_q.push_back(b);
    end else begin
      for (k = 0; k < len_byte && k < PAYLOAD_DEPTH_DEF; k++) begin
        b.payload_length  = len_byte;
        b.payload_byte    = payload_mem[k[MEM_AW-1:0]];
        b.payload_present = 1'b1;
        b.last_of_frame   = (k + 1 == len_byte);
        frame_run_q.push_back(b);
      end
    end
  endtask

  task automatic resync();
    hunt_phase = PH_SYNC1;
    data_cnt   = '0;
    sum_acc    = '0;
  endtask

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    case (hunt_phase)
      PH_SYNC1: begin
        if (b == sync_first) begin
          sum_acc    = '0;
          hunt_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == sync_second) hunt_phase = PH_CHECK;
        else resync();
      end
      PH_CHECK: begin
        check_byte = b;
        hunt_phase = PH_TYPE;
      end
      PH_TYPE: begin
        sum_acc    = sum_acc + b;
        hdr_type   = b;
        hunt_phase = PH_SRC;
      end
      PH_SRC: begin
        sum_acc    = sum_acc + b;
        hdr_src    = b;
        hunt_phase = PH_DST;
      end
      PH_DST: begin
        sum_acc    = sum_acc + b;
        hdr_dst    = b;
        hunt_phase = PH_FUNC;
      end
      PH_FUNC: begin
        sum_acc    = sum_acc + b;
        hdr_func   = b;
        hunt_phase = PH_LEN;
      end
      PH_LEN: begin
        sum_acc = sum_acc + b;
        if (b > {1'b0, max_len} || b > PAYLOAD_DEPTH_DEF) begin
          resync();
        end else begin
          len_byte = b[LEN_W-1:0];
          if (b == 0) begin
            if (sum_acc == check_byte) queue_frame_run();
            resync();
          end else begin
            data_cnt   = '0;
            hunt_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (data_cnt < PAYLOAD_DEPTH_DEF) payload_mem[data_cnt[MEM_AW-1:0]] = b;
        data_cnt = data_cnt + LEN_W'(1);
        sum_acc  = sum_acc + b;
        if (data_cnt >= len_byte) begin
          if (sum_acc == check_byte) queue_frame_run();
          resync();
        end
      end
      default: resync();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_beat_t got;
    frame_beat_t want;
    if (!rst_ni) begin
      sync_first  = SYNC_FIRST_RST;
      sync_second = SYNC_SECOND_RST;
      max_len     = MAX_LEN_RST;
      check_byte  = '0;
      hdr_type    = '0;
      hdr_src     = '0;
      hdr_dst     = '0;
      hdr_func    = '0;
      len_byte    = '0;
      resync();
      frame_run_q.delete();
      mismatches  = 0;
      mismatch_count_o <= 0;
      beats_queued_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.msg_type        = msg_type_i;
        got.source_module   = source_module_i;
        got.dest_module     = dest_module_i;
        got.function_code   = function_code_i;
        got.payload_length  = payload_length_i;
        got.payload_byte    = payload_byte_i;
        got.payload_present = payload_present_i;
        got.last_of_frame   = last_of_frame_i;
        if (frame_run_q.size() == 0) begin
          $error("output beat with none outstanding: msg_type %0d payload_byte %0d",
                 got.msg_type, got.payload_byte);
          mismatches++;
        end else begin
          want = frame_run_q.pop_front();
          mismatches += field_mismatch("msg_type", want.msg_type, got.msg_type);
          mismatches += field_mismatch("source_module", want.source_module,
                                       got.source_module);
          mismatches += field_mismatch("dest_module", want.dest_module, got.dest_module);
          mismatches += field_mismatch("function_code", want.function_code,
                                       got.function_code);
          mismatches += field_mismatch("payload_length", BYTE_W'(want.payload_length),
                                       BYTE_W'(got.payload_length));
          mismatches += field_mismatch("payload_byte", want.payload_byte, got.payload_byte);
          mismatches += field_mismatch("payload_present", BYTE_W'(want.payload_present),
                                       BYTE_W'(got.payload_present));
          mismatches += field_mismatch("last_of_frame", BYTE_W'(want.last_of_frame),
                                       BYTE_W'(got.last_of_frame));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SYNC_FIRST:  sync_first  = cfg_data_i;
          CFG_SYNC_SECOND: sync_second = cfg_data_i;
          CFG_MAX_LEN:     max_len     = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) parse_rx_byte(rx_byte_i);
      mismatch_count_o <= mismatches;
      beats_queued_o   <= frame_run_q.size();
    end
  end

endmodule

[sim/tb_framed_packet_receiver.sv]
// testbench top for the framed packet receiver: stimulus, output stalls and verdict
`timescale 1ns / 1ps

module tb_framed_packet_receiver;
  import fpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET   = 220;
  localparam int unsigned PHASE_BYTES   = 30;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid_o;
  logic                 out_stall;
  logic [BYTE_W-1:0]    msg_type_o;
  logic [BYTE_W-1:0]    source_module_o;
  logic [BYTE_W-1:0]    dest_module_o;
  logic [BYTE_W-1:0]    function_code_o;
  logic [LEN_W-1:0]     payload_length_o;
  logic [BYTE_W-1:0]    payload_byte_o;
  logic                 payload_present_o;
  logic                 last_of_frame_o;

  int unsigned mismatches;
  int unsigned beats_queued;

  int unsigned in_gap_max = 3;
  int unsigned stall_max  = 3;
  int unsigned stall_left;
  int unsigned bytes_sent = 0;
  int unsigned cycles;

  logic [BYTE_W-1:0] cur_s1  = SYNC_FIRST_RST;
  logic [BYTE_W-1:0] cur_s2  = SYNC_SECOND_RST;
  logic [LEN_W-1:0]  cur_max = MAX_LEN_RST;

  always #5 clk = ~clk;

  framed_packet_receiver dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .msg_type_o        (msg_type_o),
    .source_module_o   (source_module_o),
    .dest_module_o     (dest_module_o),
    .function_code_o   (function_code_o),
    .payload_length_o  (payload_length_o),
    .payload_byte_o    (payload_byte_o),
    .payload_present_o (payload_present_o),
    .last_of_frame_o   (last_of_frame_o)
  );

  fpr_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall_o),
    .rx_byte_i         (rx_byte),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall),
    .msg_type_i        (msg_type_o),
    .source_module_i   (source_module_o),
    .dest_module_i     (dest_module_o),
    .function_code_i   (function_code_o),
    .payload_length_i  (payload_length_o),
    .payload_byte_i    (payload_byte_o),
    .payload_present_i (payload_present_o),
    .last_of_frame_i   (last_of_frame_o),
    .mismatch_count_o  (mismatches),
    .beats_queued_o    (beats_queued)
  );

  // random receiver stalls: after each beat, and now and then while idle
  always @(posedge clk or negedge rst_n) begin : stall_gen
    int unsigned draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      draw = $urandom_range(0, stall_max);
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (!out_valid_o && stall_max != 0 && $urandom_range(0, 3) == 0) begin
      draw = $urandom_range(1, stall_max);
      stall_left <= draw;
      out_stall  <= 1'b1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] ty, input logic [BYTE_W-1:0] src,
                            input logic [BYTE_W-1:0] dst, input logic [BYTE_W-1:0] fn,
                            input logic [BYTE_W-1:0] len, input bit bad_sum);
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] delta;
    logic [BYTE_W-1:0] b;
    int i;
    sum = ty + src + dst + fn + len;
    // an over-long length ends the frame at the length byte
    if (len <= cur_max) begin
      for (i = 0; i < len; i++) begin
        b = BYTE_W'($urandom_range(0, 255));
        body.push_back(b);
        sum = sum + b;
      end
    end
    delta = BYTE_W'($urandom_range(1, 255));
    send_byte(cur_s1);
    send_byte(cur_s2);
    send_byte(bad_sum ? sum + delta : sum);
    send_byte(ty);
    send_byte(src);
    send_byte(dst);
    send_byte(fn);
    send_byte(len);
    foreach (body[j]) send_byte(body[j]);
  endtask

  task automatic send_any_frame(input logic [BYTE_W-1:0] len, input bit bad_sum);
    send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
               BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
               len, bad_sum);
  endtask

  task automatic send_random_traffic();
    int unsigned pick;
    int unsigned n;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 3) == 0) begin
      in_gap_max = 0;
      stall_max  = 0;
    end else begin
      in_gap_max = 3;
      stall_max  = 3;
    end
    pick = $urandom_range(0, 19);
    if (pick < 15) begin
      if ($urandom_range(0, 9) == 0) len = {1'b0, cur_max};
      else len = BYTE_W'($urandom_range(0, (cur_max < 6) ? cur_max : 6));
      send_any_frame(len, pick >= 13);
    end else if (pick < 17) begin
      send_any_frame(BYTE_W'($urandom_range(cur_max + 1, 255)), 1'b0);
    end else if (pick < 18) begin
      b = BYTE_W'($urandom_range(0, 255));
      if (b == cur_s2) b = ~b;
      send_byte(cur_s1);
      send_byte(b);
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_queued != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                           input logic [LEN_W-1:0] mx);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SYNC_FIRST;
    cfg_data <= s1;
    @(posedge clk);
    cfg_idx  <= CFG_SYNC_SECOND;
    cfg_data <= s2;
    @(posedge clk);
    cfg_idx  <= CFG_MAX_LEN;
    cfg_data <= {1'b0, mx};
    @(posedge clk);
    // unused index must leave every register alone
    cfg_idx  <= CFG_IDX_UNUSED;
    cfg_data <= BYTE_W'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_s1  = s1;
    cur_s2  = s2;
    cur_max = mx;
  endtask

  initial begin : timeout
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_framed_packet_receiver: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned phase_start;
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= CFG_SYNC_FIRST;
    cfg_data <= '0;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames with the register defaults
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0);
    send_byte(cur_s1);
    send_byte(cur_s1);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, {1'b0, cur_max} + 8'd1, 1'b0);
    send_frame(8'h01, 8'h02, 8'h03, 8'h04, 8'd0, 1'b1);
    send_frame(8'h00, 8'h80, 8'h7F, 8'h01, 8'd2, 1'b0);

    for (phase_no = 0; bytes_sent < ITEM_TARGET; phase_no++) begin
      drain();
      in_gap_max = 3;
      stall_max  = 3;
      case (phase_no)
        0: configure(8'h00, 8'hFF, 7'd64);
        1: configure(8'hFF, 8'h00, 7'd0);
        default: configure(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                           LEN_W'($urandom_range(1, 64)));
      endcase
      if (cur_max == PAYLOAD_DEPTH_DEF || cur_max == 0) begin
        send_any_frame({1'b0, cur_max}, 1'b0);
        send_any_frame({1'b0, cur_max} + 8'd1, 1'b0);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_traffic();
    end

    drain();
    if (mismatches == 0 && beats_queued == 0) begin
      $display("tb_framed_packet_receiver: PASS");
    end else begin
      $display("tb_framed_packet_receiver: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/fpr_pkg.sv
sv/fpr_ram.sv
sv/framed_packet_receiver.sv
sim/fpr_checker.sv
sim/tb_framed_packet_receiver.sv
